>>> rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/mfau_pkg.sv
// Shared constants and types of the mixed fraction arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package mfau_pkg;
   localparam int OPERAND_WIDTH_DEFAULT = 16;
   localparam int RES_WIDTH = 48;
   localparam int DEN_WIDTH = 47;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_COMB,
      ST_DIV,
      ST_GCD,
      ST_GSHIFT,
      ST_RED,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> rtl/mixed_fraction_arithmetic_unit.sv
// Mixed number add, subtract, multiply and divide with gcd reduction, bit-serial datapath.
// The run time is set by the bit-serial multiply loop, the restoring divider (one quotient bit a
// cycle, used twice) and the binary gcd loop with its restore of the shared factors of two; a zero
// denominator goes from setup straight to done, a zero divisor from the combine step to done.
// Requests are accepted only in the idle state, so one operation runs at a time; the done state
// holds the result until the previous response has been taken.
// Reset is synchronous and active high; it clears the sequencer and the response valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mixed_fraction_arithmetic_unit #(
   parameter int OPERAND_WIDTH = mfau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // x_whole, x_num, x_denom, y_whole, y_num, y_denom from bit 0 up, zero padded
   input  wire logic [((6*OPERAND_WIDTH-2+7)/8)*8-1:0] req_tdata,
   // mode
   input  wire logic [1:0] req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // res_whole, res_num, res_denom from bit 0 up, zero padded
   output logic [143:0] rsp_tdata,
   // error
   output logic      rsp_tuser
);
   localparam int W  = OPERAND_WIDTH;
   localparam int XW = 2*W+1;
   localparam int NW = 4*W+1;
   localparam int DW = 3*W;
   localparam int CW = $clog2(NW);
   localparam int KW = $clog2(DW+1);
   localparam int EW = (NW > 49) ? NW : 49;
   localparam int RW = mfau_pkg::RES_WIDTH;
   localparam int FW = mfau_pkg::DEN_WIDTH;
   localparam logic [EW-1:0] LIM = EW'(1) << FW;

   mfau_pkg::state_type state_ff, state_in;

   logic [1:0] mode_ff, mode_in;
   logic err_ff, err_in;
   logic neg_ff, neg_in;
   logic [W-2:0] xd_ff, xd_in, yd_ff, yd_in;
   logic signed [XW-1:0] xv_ff, xv_in, yv_ff, yv_in;
   logic signed [NW-1:0] ma_ff, ma_in, mb_ff, mb_in, pa_ff, pa_in, pb_ff, pb_in;
   logic [XW-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in, bq_ff, bq_in, qs_ff, qs_in;
   logic [DW-1:0] rem_ff, rem_in, brem_ff, brem_in, dv_ff, dv_in;
   logic [DW-1:0] ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in;
   logic [KW-1:0] k_ff, k_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_err_ff, rsp_err_in;
   logic [143:0] rsp_data_ff, rsp_data_in;

   // Request fields.
   logic signed [W-1:0] in_xw, in_xn, in_yw, in_yn;
   logic [W-2:0] in_xd, in_yd;
   assign in_xw = req_tdata[W-1:0];
   assign in_xn = req_tdata[2*W-1:W];
   assign in_xd = req_tdata[3*W-2:2*W];
   assign in_yw = req_tdata[4*W-2:3*W-1];
   assign in_yn = req_tdata[5*W-2:4*W-1];
   assign in_yd = req_tdata[6*W-3:5*W-1];

   // Improper numerators: d*w, with the fraction subtracted for a negative whole part.
   logic signed [XW-1:0] xd_s, xw_s, xn_s, yd_s, yw_s, yn_s, x_val, y_val;
   always_comb begin
      xd_s = $signed(XW'({1'b0, in_xd}));
      yd_s = $signed(XW'({1'b0, in_yd}));
      xw_s = XW'(in_xw);
      xn_s = XW'(in_xn);
      yw_s = XW'(in_yw);
      yn_s = XW'(in_yn);
      x_val = XW'(xd_s * xw_s) + ((xw_s < 0) ? -xn_s : xn_s);
      y_val = XW'(yd_s * yw_s) + ((yw_s < 0) ? -yn_s : yn_s);
   end

   // Restoring divider shared by the quotient pass and the reduction pass.
   logic [DW-1:0] dsr, ra_next, rb_next;
   logic [DW:0] ta, tb, tda, tdb;
   logic gea, geb;
   logic [NW-1:0] qa_next, qb_next;
   always_comb begin
      dsr = (state_ff == mfau_pkg::ST_DIV) ? dv_ff : g_ff;
      ta = {rem_ff, quo_ff[NW-1]};
      tb = {brem_ff, bq_ff[NW-1]};
      tda = ta - {1'b0, dsr};
      tdb = tb - {1'b0, dsr};
      gea = ta >= {1'b0, dsr};
      geb = tb >= {1'b0, dsr};
      ra_next = gea ? tda[DW-1:0] : ta[DW-1:0];
      rb_next = geb ? tdb[DW-1:0] : tb[DW-1:0];
      qa_next = {quo_ff[NW-2:0], gea};
      qb_next = {bq_ff[NW-2:0], geb};
   end

   // Combine step values.
   logic signed [NW-1:0] sum_v, diff_v, nval, pbmag;
   logic [2*W-3:0] dprod;
   always_comb begin
      sum_v = pa_ff + pb_ff;
      diff_v = pa_ff - pb_ff;
      pbmag = (pb_ff < 0) ? -pb_ff : pb_ff;
      dprod = (2*W-2)'(xd_ff) * (2*W-2)'(yd_ff);
   end

   // Result formatting.
   logic [EW-1:0] qext, dext, nume, lim;
   logic [RW-1:0] q48, n48;
   logic ovf;
   always_comb begin
      qext = EW'(qs_ff);
      dext = EW'(bq_ff);
      nume = EW'(quo_ff);
      lim = neg_ff ? LIM : LIM - EW'(1);
      ovf = (qext > lim) || (dext >= LIM);
      q48 = qext[RW-1:0];
      n48 = nume[RW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      err_in = err_ff;
      neg_in = neg_ff;
      xd_in = xd_ff;
      yd_in = yd_ff;
      xv_in = xv_ff;
      yv_in = yv_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      bq_in = bq_ff;
      qs_in = qs_ff;
      rem_in = rem_ff;
      brem_in = brem_ff;
      dv_in = dv_ff;
      ga_in = ga_ff;
      gb_in = gb_ff;
      g_in = g_ff;
      k_in = k_ff;
      nval = pa_ff;
      rsp_data_in = rsp_data_ff;
      rsp_err_in = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready = (state_ff == mfau_pkg::ST_IDLE);

      unique case (state_ff)
         mfau_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               xd_in = in_xd;
               yd_in = in_yd;
               xv_in = x_val;
               yv_in = y_val;
               err_in = (in_xd == '0) || (in_yd == '0);
               state_in = mfau_pkg::ST_SETUP;
            end
         end
         mfau_pkg::ST_SETUP: begin
            pa_in = '0;
            pb_in = '0;
            cnt_in = '0;
            if (mode_ff == mfau_pkg::MODE_MUL) begin
               ma_in = (xv_ff < 0) ? NW'(-xv_ff) : NW'(xv_ff);
               ra_in = (yv_ff < 0) ? XW'(-yv_ff) : XW'(yv_ff);
               mb_in = '0;
               rb_in = '0;
            end else begin
               // Cross products X*yd and Y*xd serve add, subtract and divide alike.
               ma_in = NW'(xv_ff);
               ra_in = XW'(yd_ff);
               mb_in = NW'(yv_ff);
               rb_in = XW'(xd_ff);
            end
            state_in = err_ff ? mfau_pkg::ST_DONE : mfau_pkg::ST_MUL;
         end
         mfau_pkg::ST_MUL: begin
            if (ra_ff[0]) pa_in = pa_ff + ma_ff;
            if (rb_ff[0]) pb_in = pb_ff + mb_ff;
            ma_in = ma_ff <<< 1;
            mb_in = mb_ff <<< 1;
            ra_in = ra_ff >> 1;
            rb_in = rb_ff >> 1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(XW-1)) state_in = mfau_pkg::ST_COMB;
         end
         mfau_pkg::ST_COMB: begin
            dv_in = DW'(dprod);
            unique case (mode_ff)
               mfau_pkg::MODE_ADD: begin
                  nval = sum_v;
                  neg_in = sum_v < 0;
               end
               mfau_pkg::MODE_SUB: begin
                  nval = diff_v;
                  neg_in = diff_v < 0;
               end
               mfau_pkg::MODE_MUL: begin
                  nval = pa_ff;
                  neg_in = (xv_ff < 0) != (yv_ff < 0);
               end
               default: begin
                  nval = pa_ff;
                  neg_in = (pa_ff < 0) != (pb_ff < 0);
                  dv_in = pbmag[DW-1:0];
               end
            endcase
            quo_in = (nval < 0) ? NW'(-nval) : NW'(nval);
            rem_in = '0;
            cnt_in = '0;
            if (mode_ff == mfau_pkg::MODE_DIV && pb_ff == '0) begin
               err_in = 1'b1;
               state_in = mfau_pkg::ST_DONE;
            end else begin
               state_in = mfau_pkg::ST_DIV;
            end
         end
         mfau_pkg::ST_DIV: begin
            quo_in = qa_next;
            rem_in = ra_next;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW-1)) begin
               qs_in = qa_next;
               ga_in = dv_ff;
               gb_in = ra_next;
               k_in = '0;
               state_in = mfau_pkg::ST_GCD;
            end
         end
         mfau_pkg::ST_GCD: begin
            // Binary gcd: common factors of two are counted in k and restored later.
            if (ga_ff == '0) begin
               g_in = gb_ff;
               state_in = mfau_pkg::ST_GSHIFT;
            end else if (gb_ff == '0) begin
               g_in = ga_ff;
               state_in = mfau_pkg::ST_GSHIFT;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff >= gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         mfau_pkg::ST_GSHIFT: begin
            if (k_ff == '0) begin
               quo_in = NW'(rem_ff);
               rem_in = '0;
               bq_in = NW'(dv_ff);
               brem_in = '0;
               cnt_in = '0;
               state_in = mfau_pkg::ST_RED;
            end else begin
               g_in = g_ff << 1;
               k_in = k_ff - KW'(1);
            end
         end
         mfau_pkg::ST_RED: begin
            quo_in = qa_next;
            rem_in = ra_next;
            bq_in = qb_next;
            brem_in = rb_next;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW-1)) state_in = mfau_pkg::ST_DONE;
         end
         mfau_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (err_ff || ovf) begin
                  rsp_err_in = 1'b1;
                  rsp_data_in = {1'b0, FW'(1), RW'(0), RW'(0)};
               end else begin
                  rsp_err_in = 1'b0;
                  rsp_data_in = {1'b0, dext[FW-1:0],
                                 (qs_ff == '0 && neg_ff) ? -n48 : n48,
                                 neg_ff ? -q48 : q48};
               end
               state_in = mfau_pkg::ST_IDLE;
            end
         end
         default: state_in = mfau_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      err_ff <= err_in;
      neg_ff <= neg_in;
      xd_ff <= xd_in;
      yd_ff <= yd_in;
      xv_ff <= xv_in;
      yv_ff <= yv_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      bq_ff <= bq_in;
      qs_ff <= qs_in;
      rem_ff <= rem_in;
      brem_ff <= brem_in;
      dv_ff <= dv_in;
      ga_ff <= ga_in;
      gb_ff <= gb_in;
      g_ff <= g_in;
      k_ff <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_err_ff;

   `ASSERT_AT(a_err_result, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[95:0] == '0 && rsp_tdata[142:96] == 47'd1, "error result is not zero over one")
   `ASSERT_AT(a_denom_nz, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[142:96] != '0, "zero denominator in a valid result")
   `ASSERT_AT(a_divisor_nz, clock, reset, state_ff == mfau_pkg::ST_DIV |-> dv_ff != '0, "divide pass started with a zero divisor")
   `ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, state_ff != mfau_pkg::ST_IDLE, "request transfer did not start the sequencer")
endmodule
`default_nettype wire
